### hdl/sat_pkg.sv
`timescale 1ns / 1ps
// Shared definitions for the section address translator.
// Holds field widths, item mode codes, register indexes and the control structs.
// Depends on nothing.
package sat_pkg;

  localparam int SECTION_SLOTS_DEF = 16;

  localparam int ADDR_W  = 32;
  localparam int RES_W   = 33;
  localparam int MODE_W  = 2;
  localparam int EIDX_W  = 4;
  localparam int COUNT_W = 5;
  localparam int CFG_IDX_W = 1;

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 40;

  // Item modes carried on in_tuser.
  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_V2F    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_F2V    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SIZE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTION_COUNT = 1'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // write the item's entry into the table
    logic start;    // latch a translate item and check the direct cases
    logic scan;     // evaluate the table entry read in the previous cycle
    logic advance;  // move on to the next table entry
    logic emit;     // move the pending result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic direct;   // translate item is settled without a table scan
    logic stop;     // current scan step ends the scan
  } sts_t;

endpackage

### hdl/section_address_translator_core.sv
`timescale 1ns / 1ps
// Timing: a load item is written at the edge that accepts it. A translate item settled without
// the table (file-to-virtual header pass-through or no sections) goes straight to the emit
// state; one that scans k entries (1 to SECTION_SLOTS) first reads them in turn through the
// single table read port. Throughput: one item at a time; a translate item holds the input until
// its result has moved to the output register, which may wait on out_tready. A load does not.
// Reset (rst_n, synchronous, active low) clears the FSM, output valid, config registers and scan index only.
module section_address_translator_core #(
  parameter int SECTION_SLOTS = sat_pkg::SECTION_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [sat_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sat_pkg::ADDR_W-1:0]        cfg_wdata,
  // Input items.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // in_tdata, from bit 0: entry_index[3:0], entry_virtual_base[35:4],
  // entry_raw_position[67:36], entry_raw_size[99:68], query_address[131:100], zero pad.
  input  logic [sat_pkg::IN_DATA_W-1:0]     in_tdata,
  // in_tuser: mode.
  input  logic [sat_pkg::MODE_W-1:0]        in_tuser,
  // Result items.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tdata, from bit 0: translated_address[32:0], zero pad.
  output logic [sat_pkg::OUT_DATA_W-1:0]    out_tdata,
  // out_tuser: not_found.
  output logic                              out_tuser
);
  import sat_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [RES_W-1:0] translated_address;
  logic             not_found;

  // Unpack the input item fields.
  logic [EIDX_W-1:0] entry_index;
  logic [ADDR_W-1:0] entry_virtual_base, entry_raw_position, entry_raw_size, query_address;

  assign entry_index        = in_tdata[3:0];
  assign entry_virtual_base = in_tdata[35:4];
  assign entry_raw_position = in_tdata[67:36];
  assign entry_raw_size     = in_tdata[99:68];
  assign query_address      = in_tdata[131:100];

  // The controller sequences the item: load, direct result, or a scan one entry per cycle,
  // then hands the result to the output register as soon as it is free.
  sat_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_mode    (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .sts        (sts),
    .cmd        (cmd)
  );

  // The datapath holds the configuration, the section table and the result registers.
  sat_dp #(
    .SECTION_SLOTS (SECTION_SLOTS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_mode            (in_tuser),
    .entry_index        (entry_index),
    .entry_virtual_base (entry_virtual_base),
    .entry_raw_position (entry_raw_position),
    .entry_raw_size     (entry_raw_size),
    .query_address      (query_address),
    .cmd                (cmd),
    .sts                (sts),
    .translated_address (translated_address),
    .not_found          (not_found)
  );

  assign out_tdata = {{(OUT_DATA_W - RES_W){1'b0}}, translated_address};
  assign out_tuser = not_found;

  // A miss always reports a zero address.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[RES_W-1:0] == '0)
    else $error("miss result carries a nonzero address");

  // A new result never overwrites one that is still waiting to be taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_tvalid || out_tready))
    else $error("result register overwritten while held");

  // No new item is taken while a scan is running.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> !in_tready)
    else $error("input accepted during a scan");

endmodule

### hdl/sat_ram.sv
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read data.
// Stand-alone; no package needed.
module sat_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/sat_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the section address translator.
// Uses sat_pkg for mode codes and the command and status structs.
module sat_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic [sat_pkg::MODE_W-1:0]  in_mode,
  output logic                        in_tready,
  input  logic                        out_tready,
  output logic                        out_tvalid,
  input  sat_pkg::sts_t               sts,
  output sat_pkg::cmd_t               cmd
);
  import sat_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_LOAD: begin
              cmd.load = 1'b1;
            end
            MODE_V2F, MODE_F2V: begin
              cmd.start = 1'b1;
              state_nxt = sts.direct ? S_EMIT : S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.stop) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hdl/sat_dp.sv
`timescale 1ns / 1ps
// Datapath of the section address translator: configuration registers,
// section table memory, scan arithmetic and result registers.
// Uses sat_pkg and sat_ram.
module sat_dp #(
  parameter int SECTION_SLOTS = sat_pkg::SECTION_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sat_pkg::ADDR_W-1:0]     cfg_wdata,
  input  logic [sat_pkg::MODE_W-1:0]     in_mode,
  input  logic [sat_pkg::EIDX_W-1:0]     entry_index,
  input  logic [sat_pkg::ADDR_W-1:0]     entry_virtual_base,
  input  logic [sat_pkg::ADDR_W-1:0]     entry_raw_position,
  input  logic [sat_pkg::ADDR_W-1:0]     entry_raw_size,
  input  logic [sat_pkg::ADDR_W-1:0]     query_address,
  input  sat_pkg::cmd_t                  cmd,
  output sat_pkg::sts_t                  sts,
  output logic [sat_pkg::RES_W-1:0]      translated_address,
  output logic                           not_found
);
  import sat_pkg::*;

  localparam int IDX_W   = (SECTION_SLOTS > 1) ? $clog2(SECTION_SLOTS) : 1;
  localparam int CNT_W   = ($clog2(SECTION_SLOTS + 1) > COUNT_W) ?
                           $clog2(SECTION_SLOTS + 1) : COUNT_W;
  localparam int ENTRY_W = 3 * ADDR_W;

  // Configuration registers.
  logic [ADDR_W-1:0]  header_size_r;
  logic [COUNT_W-1:0] section_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_size_r   <= '0;
      section_count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEADER_SIZE:   header_size_r   <= cfg_wdata;
        CFG_SECTION_COUNT: section_count_r <= cfg_wdata[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Number of entries the scan may visit.
  logic [CNT_W-1:0] count_ext, active;
  assign count_ext = CNT_W'(section_count_r);
  assign active    = (count_ext > CNT_W'(SECTION_SLOTS)) ? CNT_W'(SECTION_SLOTS) : count_ext;

  // Section table: {raw size, raw position, virtual base} per entry.
  logic [31:0]        eidx_ext;
  logic               load_we;
  logic [IDX_W-1:0]   waddr, raddr;
  logic [ENTRY_W-1:0] rd_entry;
  logic [IDX_W-1:0]   idx_r;

  assign eidx_ext = 32'(entry_index);
  assign load_we  = cmd.load && (eidx_ext < 32'(SECTION_SLOTS));
  assign waddr    = eidx_ext[IDX_W-1:0];
  assign raddr    = cmd.advance ? idx_r + 1'b1 : '0;

  sat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SECTION_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (load_we),
    .waddr (waddr),
    .wdata ({entry_raw_size, entry_raw_position, entry_virtual_base}),
    .raddr (raddr),
    .rdata (rd_entry)
  );

  // Latched translate item.
  logic [MODE_W-1:0] mode_r;
  logic [ADDR_W-1:0] addr_r;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_r <= in_mode;
      addr_r <= query_address;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.start) begin
      idx_r <= '0;
    end else if (cmd.advance) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // Direct cases, decided on the incoming item.
  logic in_below_hdr;
  assign in_below_hdr = query_address < header_size_r;
  assign sts.direct   = (active == '0) || ((in_mode == MODE_F2V) && in_below_hdr);

  // One scan step on the entry read in the previous cycle.
  logic [ADDR_W-1:0] e_vbase, e_rpos, e_rsize, from_base, to_base, diff;
  logic [ADDR_W:0]   sub;
  logic [RES_W-1:0]  sum;
  logic              below, covered, last, first, hdr_hit;

  assign e_vbase   = rd_entry[ADDR_W-1:0];
  assign e_rpos    = rd_entry[2*ADDR_W-1:ADDR_W];
  assign e_rsize   = rd_entry[3*ADDR_W-1:2*ADDR_W];
  assign from_base = (mode_r == MODE_V2F) ? e_vbase : e_rpos;
  assign to_base   = (mode_r == MODE_V2F) ? e_rpos : e_vbase;
  assign sub       = {1'b0, addr_r} - {1'b0, from_base};
  assign below     = sub[ADDR_W];
  assign diff      = sub[ADDR_W-1:0];
  assign covered   = diff < e_rsize;
  assign sum       = {1'b0, diff} + {1'b0, to_base};
  assign first     = (idx_r == '0);
  assign last      = (CNT_W'(idx_r) + 1'b1) == active;
  assign hdr_hit   = addr_r < header_size_r;
  assign sts.stop  = below || covered || last;

  // Pending result, then the output register.
  logic [RES_W-1:0] pend_res_r, out_res_r;
  logic             pend_nf_r, out_nf_r;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      // Only used when the item is direct; file-to-virtual is then always a hit.
      if ((in_mode == MODE_V2F) && !in_below_hdr) begin
        pend_res_r <= '0;
        pend_nf_r  <= 1'b1;
      end else begin
        pend_res_r <= RES_W'(query_address);
        pend_nf_r  <= 1'b0;
      end
    end else if (cmd.scan) begin
      if (below) begin
        // Below the first section's virtual base, a virtual address may
        // still fall in the header area.
        if ((mode_r == MODE_V2F) && first && hdr_hit) begin
          pend_res_r <= RES_W'(addr_r);
          pend_nf_r  <= 1'b0;
        end else begin
          pend_res_r <= '0;
          pend_nf_r  <= 1'b1;
        end
      end else if (covered) begin
        pend_res_r <= sum;
        pend_nf_r  <= 1'b0;
      end else begin
        pend_res_r <= '0;
        pend_nf_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_res_r <= pend_res_r;
      out_nf_r  <= pend_nf_r;
    end
  end

  assign translated_address = out_res_r;
  assign not_found          = out_nf_r;

endmodule

### tb/sv/section_translation_checker.sv
`timescale 1ns / 1ps
// Result checker for section_address_translator_core: keeps its own section table and
// registers, predicts every translate result and compares the result stream against it.
// Depends on sat_pkg.
module section_translation_checker
  import sat_pkg::*;
#(
  parameter int SECTION_SLOTS = SECTION_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [ADDR_W-1:0]     cfg_wdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [MODE_W-1:0]     in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tuser,
  output int                    mismatches,
  output int                    results_due
);

  typedef struct packed {
    logic [RES_W-1:0] addr;
    logic             miss;
  } translation_t;

  translation_t pending_translations[$];

  logic [ADDR_W-1:0]  hdr_size;
  logic [COUNT_W-1:0] sect_count;
  logic [ADDR_W-1:0]  sect_vbase [SECTION_SLOTS];
  logic [ADDR_W-1:0]  sect_rpos  [SECTION_SLOTS];
  logic [ADDR_W-1:0]  sect_rsize [SECTION_SLOTS];

  // Header pass-through first, then an in-order scan that gives up as soon as the
  // address lies below the entry being looked at.
  function automatic translation_t translate_address(input logic [MODE_W-1:0] mode,
                                                     input logic [ADDR_W-1:0] addr);
    translation_t     res;
    int               active;
    int               i;
    logic             hit;
    logic             done;
    logic [ADDR_W-1:0] from_b;
    logic [ADDR_W-1:0] to_b;
    logic [ADDR_W-1:0] diff;
    logic [RES_W-1:0]  sum;
    active = (sect_count > SECTION_SLOTS) ? SECTION_SLOTS : int'(sect_count);
    hit = 1'b0;
    sum = '0;
    if (mode == MODE_V2F && (active == 0 || addr < sect_vbase[0])) begin
      hit = addr < hdr_size;
      sum = {1'b0, addr};
    end else if (mode == MODE_F2V && (active == 0 || addr < hdr_size)) begin
      hit = 1'b1;
      sum = {1'b0, addr};
    end else begin
      done = 1'b0;
      for (i = 0; i < active && !done; i++) begin
        from_b = (mode == MODE_V2F) ? sect_vbase[i] : sect_rpos[i];
        to_b   = (mode == MODE_V2F) ? sect_rpos[i] : sect_vbase[i];
        if (addr < from_b) begin
          done = 1'b1;
        end else begin
          diff = addr - from_b;
          if (diff < sect_rsize[i]) begin
            hit  = 1'b1;
            done = 1'b1;
            sum  = {1'b0, diff} + {1'b0, to_b};
          end
        end
      end
    end
    res.addr = hit ? sum : '0;
    res.miss = !hit;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    translation_t want;
    translation_t got;
    if (!rst_n) begin
      hdr_size   = '0;
      sect_count = '0;
      pending_translations.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_HEADER_SIZE) hdr_size = cfg_wdata;
        else if (cfg_index == CFG_SECTION_COUNT) sect_count = cfg_wdata[COUNT_W-1:0];
      end
      // A result always belongs to an item accepted at an earlier edge.
      if (out_tvalid && out_tready) begin
        got.addr = out_tdata[RES_W-1:0];
        got.miss = out_tuser;
        if (pending_translations.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got addr %h not_found %b",
                   $time, got.addr, got.miss);
        end else begin
          want = pending_translations.pop_front();
          if (got.addr !== want.addr) begin
            mismatches++;
            $display("%0t: translated_address mismatch, expected %h, got %h",
                     $time, want.addr, got.addr);
          end
          if (got.miss !== want.miss) begin
            mismatches++;
            $display("%0t: not_found mismatch, expected %b, got %b",
                     $time, want.miss, got.miss);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          MODE_LOAD: begin
            sect_vbase[in_tdata[3:0]] = in_tdata[35:4];
            sect_rpos[in_tdata[3:0]]  = in_tdata[67:36];
            sect_rsize[in_tdata[3:0]] = in_tdata[99:68];
          end
          MODE_V2F, MODE_F2V:
            pending_translations.push_back(translate_address(in_tuser, in_tdata[131:100]));
          default: ;
        endcase
      end
    end
    results_due = pending_translations.size();
  end

endmodule

### tb/sv/section_address_translator_core_test.sv
`timescale 1ns / 1ps
// Top of the section address translator testbench: clock, reset, configuration writes,
// item stimulus and the verdict. Depends on sat_pkg, section_translation_checker and the core.
module section_address_translator_core_test;
  import sat_pkg::*;

  localparam int SLOTS = SECTION_SLOTS_DEF;
  // Longest translate item is a full scan of every slot; a margin on top.
  localparam int SETTLE_CYCLES = SLOTS + 6;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 200;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [ADDR_W-1:0]     cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [MODE_W-1:0]     in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  int mismatches;
  int results_due;
  int cycles;

  // The stimulus keeps its own view of the table so that it can aim addresses at
  // sections, section edges and the header boundary.
  logic [ADDR_W-1:0] slot_vbase [SLOTS];
  logic [ADDR_W-1:0] slot_rpos  [SLOTS];
  logic [ADDR_W-1:0] slot_rsize [SLOTS];
  logic [ADDR_W-1:0] cur_header;
  int                cur_count;
  // While steady is set, neither side idles.
  bit                steady;

  section_address_translator_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  section_translation_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The result side stalls in about one cycle of five, except in steady stretches.
  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 20);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offers one item at a falling edge, sometimes after a short gap, and holds it until
  // the block takes it. Values sampled right after the rising edge are the ones the
  // block saw at that edge.
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [EIDX_W-1:0] idx,
                           input logic [ADDR_W-1:0] vb, input logic [ADDR_W-1:0] rp,
                           input logic [ADDR_W-1:0] rs, input logic [ADDR_W-1:0] qa);
    int gap;
    gap = (!steady && $urandom_range(0, 99) < 20) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {4'b0, qa, rs, rp, vb, idx};
    do @(posedge clk); while (!in_tready);
    if (mode == MODE_LOAD) begin
      slot_vbase[idx] = vb;
      slot_rpos[idx]  = rp;
      slot_rsize[idx] = rs;
    end
  endtask

  // Load items leave the query field random and translate items leave the entry
  // fields random, so every field bit of the item toggles.
  task automatic load_slot(input logic [EIDX_W-1:0] idx, input logic [ADDR_W-1:0] vb,
                           input logic [ADDR_W-1:0] rp, input logic [ADDR_W-1:0] rs);
    send_item(MODE_LOAD, idx, vb, rp, rs, $urandom);
  endtask

  task automatic translate(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] addr);
    send_item(mode, EIDX_W'($urandom), $urandom, $urandom, $urandom, addr);
  endtask

  // Stops offering items until every expected result has come, then lets the block
  // finish any scan that produces nothing visible.
  task automatic settle_block();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_config(input logic [ADDR_W-1:0] header, input int count);
    settle_block();
    write_reg(CFG_HEADER_SIZE, header);
    write_reg(CFG_SECTION_COUNT, ADDR_W'(count[COUNT_W-1:0]));
    cur_header = header;
    cur_count  = (count > SLOTS) ? SLOTS : count;
  endtask

  // Fills every slot with sections that rise in both virtual and file space, so scans
  // can run deep. The caller keeps the starts low enough that nothing wraps.
  task automatic build_sections(input longint v_lo, input longint r_lo,
                                input int unsigned size_max);
    longint      v;
    longint      r;
    int unsigned sz;
    v = v_lo + $urandom_range(0, size_max);
    r = r_lo + $urandom_range(0, size_max);
    for (int i = 0; i < SLOTS; i++) begin
      sz = $urandom_range(1, size_max);
      load_slot(EIDX_W'(i), v[31:0], r[31:0], sz);
      v = v + sz + $urandom_range(0, size_max);
      r = r + sz + $urandom_range(0, size_max);
    end
  endtask

  // One random item. Most are translations aimed inside a section or at its edges;
  // the rest are stray addresses, noise loads, unused-mode items and drain pauses.
  // Returns 1 when the item counts toward the total.
  task automatic random_item(output bit counted);
    int                pick;
    int                j;
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    counted = 1'b1;
    pick = $urandom_range(0, 99);
    mode = $urandom_range(0, 1) ? MODE_F2V : MODE_V2F;
    j    = (cur_count > 0) ? $urandom_range(0, cur_count - 1) : 0;
    base = (mode == MODE_V2F) ? slot_vbase[j] : slot_rpos[j];
    size = slot_rsize[j];
    if (pick < 55 && cur_count > 0) begin
      addr = base + ((size == 0) ? 0 : $urandom_range(0, size - 1));
      translate(mode, addr);
    end else if (pick < 70 && cur_count > 0) begin
      case ($urandom_range(0, 3))
        0:       addr = base - 1;
        1:       addr = base;
        2:       addr = base + size - 1;
        default: addr = base + size;
      endcase
      translate(mode, addr);
    end else if (pick < 80) begin
      addr = $urandom_range(0, 1) ? $urandom : cur_header - 1 + $urandom_range(0, 2);
      translate(mode, addr);
    end else if (pick < 90) begin
      if ($urandom_range(0, 1))
        load_slot(EIDX_W'($urandom), $urandom, $urandom, $urandom);
      else
        load_slot(EIDX_W'($urandom), $urandom_range(0, 'hFFFF), $urandom_range(0, 'hFFFF),
                  $urandom_range(0, 'h1000));
    end else if (pick < 95) begin
      send_item(MODE_UNUSED, EIDX_W'($urandom), $urandom, $urandom, $urandom, $urandom);
      counted = 1'b0;
    end else if (pick < 97) begin
      // Hold back until the block has delivered everything it owes.
      settle_block();
      counted = 1'b0;
    end else begin
      translate(mode, $urandom);
    end
  endtask

  initial begin
    int  done_items;
    bit  counted;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_HEADER_SIZE;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = MODE_LOAD;
    out_tready = 1'b0;
    steady     = 1'b0;
    cur_header = '0;
    cur_count  = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Every slot is loaded before the first translation, so no scan ever reads an
    // entry that was never written.
    build_sections($urandom_range(0, 'hFFFF), $urandom_range(0, 'hFFFF), 'h100);

    // Directed: no sections at all. Header pass-through, a miss just past the
    // header, the top file offset passing through, and an unused-mode item.
    set_config('h1000, 0);
    translate(MODE_V2F, 'h0FFF);
    translate(MODE_V2F, 'h1000);
    translate(MODE_F2V, 'hFFFF_FFFF);
    send_item(MODE_UNUSED, EIDX_W'($urandom), $urandom, $urandom, $urandom, $urandom);

    // Directed: three hand-made sections. The last one sits at the top of both
    // spaces and has the largest raw size, so its sums need the 33rd bit.
    load_slot(0, 'h2000, 'h400, 'h200);
    load_slot(1, 'h3000, 'h800, 'h1000);
    load_slot(2, 'hFFFF_0000, 'hFFFF_FFF0, 'hFFFF_FFFF);
    load_slot(3, 'hFFFF_FFFF, 'h0, 'h0);
    set_config('h1000, 3);
    translate(MODE_V2F, 'h0800);       // below the first section, inside the header
    translate(MODE_V2F, 'h1800);       // below the first section, past the header
    translate(MODE_V2F, 'h2000);
    translate(MODE_V2F, 'h21FF);
    translate(MODE_V2F, 'h2200);       // falls in the gap, scan stops at section 1
    translate(MODE_V2F, 'h3FFF);
    translate(MODE_V2F, 'hFFFF_FFFF);  // carry into the top result bit
    translate(MODE_F2V, 'h0FFF);
    translate(MODE_F2V, 'h1000);
    translate(MODE_F2V, 'hFFFF_FFFF);

    // Directed: section count above the table size, largest header, and a raw
    // size of zero in the fourth slot.
    set_config('hFFFF_FFFF, 31);
    translate(MODE_V2F, 'h0);
    translate(MODE_F2V, 'hFFFF_FFFE);
    translate(MODE_F2V, 'hFFFF_FFFF);
    set_config('h0, 4);
    translate(MODE_V2F, 'h0);
    translate(MODE_F2V, 'h0);

    // Random phases, each with its own register setting and, in all but one, a fresh table.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          set_config('h0, SLOTS);
          build_sections($urandom_range(0, 'hFFFF), $urandom_range(0, 'hFFFF), 'h100);
        end
        1: begin
          set_config('hFFFF_FFFF, SLOTS);
          build_sections($urandom_range(0, 'h0FFF_FFFF), $urandom_range(0, 'h0FFF_FFFF),
                         'h0700_0000);
        end
        2: begin
          // A long stretch with no idling on either side.
          steady = 1'b1;
          set_config($urandom_range(0, 'hFFFF), $urandom_range(1, SLOTS - 1));
          build_sections('hF000_0000 + $urandom_range(0, 'h0DE0_0000),
                         'hF000_0000 + $urandom_range(0, 'h0DE0_0000), 'h0010_0000);
        end
        3: begin
          steady = 1'b0;
          set_config($urandom, 0);
        end
        4: begin
          set_config($urandom_range(0, 'h0100_0000), 31);
          build_sections($urandom_range(0, 'h0FFF_FFFF), $urandom_range(0, 'h0FFF_FFFF),
                         'h0700_0000);
        end
        5: begin
          set_config($urandom, 1);
          build_sections($urandom_range(0, 'hFFFF), $urandom_range(0, 'hFFFF), 'h100);
        end
        6: begin
          set_config('h0, $urandom_range(SLOTS + 1, 30));
          build_sections('hF000_0000 + $urandom_range(0, 'h0DE0_0000),
                         'hF000_0000 + $urandom_range(0, 'h0DE0_0000), 'h0010_0000);
        end
        default: begin
          set_config($urandom_range(0, 'h1_0000), $urandom_range(1, SLOTS));
          build_sections($urandom_range(0, 'hFFFF), $urandom_range(0, 'hFFFF), 'h100);
        end
      endcase
      done_items = 0;
      while (done_items < PHASE_ITEMS) begin
        random_item(counted);
        if (counted) done_items++;
      end
    end

    // Drain, give the block time for any trailing output, then decide.
    settle_block();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
